/* hw/rtl/substring_delete_all_filter_core_assert.svh */
// Assertion macros for the port checker of the substring delete-all filter.
`ifndef SUBSTRING_DELETE_ALL_FILTER_CORE_ASSERT_SVH
`define SUBSTRING_DELETE_ALL_FILTER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SDAF_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define SDAF_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sdaf_pkg.sv */
// Shared constants and interface types of the substring delete-all filter.
`timescale 1ns / 1ps

package sdaf_pkg;

    // Sizes fixed by the register and field layout.
    localparam int PATTERN_MAX_DEF = 16;
    localparam int PAT_BYTES       = 16;
    localparam int BYTE_W          = 8;
    localparam int PLEN_W          = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

    // Command from the control logic to the window.
    typedef struct packed {
        logic              load;
        logic              last;
        logic              advance;
        logic [BYTE_W-1:0] in_byte;
    } win_cmd_t;

    // Outcome of one window step, as seen by the control logic.
    typedef struct packed {
        logic              cont;
        logic              emit;
        logic              empty;
        logic              next_cont;
        logic [BYTE_W-1:0] emit_byte;
    } win_status_t;

endpackage

/* hw/rtl/substring_delete_all_filter_core.sv */
// A text byte is held in the input register; bytes that its window steps emit go to the output register.
// Bytes emitted in a final byte's steps wait in the hold register first.
// Throughput: one window step per cycle while the output is not stalled; a new text byte
// enters only once the previous one needs no further window step.
// A final byte takes further steps to flush or drop the bytes still in the window and to end the text.
// Reset (rst_n low, asynchronous) empties the window and all stages and zeroes the config registers.
`timescale 1ns / 1ps

module substring_delete_all_filter_core
    import sdaf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  text_valid,
    output logic                  text_ready,
    input  logic [BYTE_W-1:0]     text_byte,
    input  logic                  end_of_text,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  byte_valid,
    output logic                  final_result
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);

    logic [FILL_W-1:0]           plen;
    logic [PAT_BYTES*BYTE_W-1:0] pattern;
    win_cmd_t                    cmd;
    win_status_t                 status;

    logic              inq_valid_reg;
    logic [BYTE_W-1:0] inq_byte_reg;
    logic              inq_last_reg;
    logic              busy_reg, busy_next;
    logic              last_reg, last_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [BYTE_W-1:0] hold_byte_reg, hold_byte_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_bv_reg, out_bv_next;
    logic              out_final_reg, out_final_next;

    logic out_free;
    logic advance;
    logic take;
    logic cur_last;
    logic finish;

    sdaf_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .plen      (plen),
        .pattern   (pattern)
    );

    sdaf_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .plen    (plen),
        .pattern (pattern),
        .status  (status)
    );

    // Step control: a new byte enters only when the previous one is fully scanned.
    always_comb
    begin
        out_free    = !out_valid_reg || result_ready;
        advance     = out_free && (busy_reg || inq_valid_reg);
        take        = advance && !busy_reg;
        cur_last    = busy_reg ? last_reg : inq_last_reg;
        finish      = cur_last && !status.cont && status.empty;
        text_ready  = !inq_valid_reg || take;
        cmd.load    = !busy_reg;
        cmd.last    = cur_last;
        cmd.advance = advance;
        cmd.in_byte = inq_byte_reg;
    end

    // Result routing. In the final text byte's step each emitted byte waits in the
    // hold register, so the last one can still be flagged as final.
    always_comb
    begin
        busy_next       = busy_reg;
        last_next       = last_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_byte_next   = out_byte_reg;
        out_bv_next     = out_bv_reg;
        out_final_next  = out_final_reg;
        if (advance)
        begin
            if (!busy_reg)
            begin
                last_next = inq_last_reg;
            end
            busy_next = cur_last ? !finish : status.next_cont;
            if (finish)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = hold_valid_reg ? hold_byte_reg : '0;
                out_bv_next     = hold_valid_reg;
                out_final_next  = 1'b1;
                hold_valid_next = 1'b0;
            end
            else if (status.emit)
            begin
                if (!cur_last)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = status.emit_byte;
                    out_bv_next    = 1'b1;
                    out_final_next = 1'b0;
                end
                else
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = hold_byte_reg;
                        out_bv_next    = 1'b1;
                        out_final_next = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_byte_next  = status.emit_byte;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg  <= 1'b0;
            busy_reg       <= 1'b0;
            last_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (text_valid && text_ready)
            begin
                inq_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                inq_valid_reg <= 1'b0;
            end
            busy_reg       <= busy_next;
            last_reg       <= last_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            inq_byte_reg <= text_byte;
            inq_last_reg <= end_of_text;
        end
        hold_byte_reg <= hold_byte_next;
        out_byte_reg  <= out_byte_next;
        out_bv_reg    <= out_bv_next;
        out_final_reg <= out_final_next;
    end

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign byte_valid   = out_bv_reg;
    assign final_result = out_final_reg;

endmodule

/* hw/rtl/sdaf_cfg.sv */
// Configuration registers: pattern length (clamped) and pattern bytes.
`timescale 1ns / 1ps

module sdaf_cfg
    import sdaf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    localparam int FILL_W = $clog2(PATTERN_MAX + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output logic [FILL_W-1:0]           plen,
    output logic [PAT_BYTES*BYTE_W-1:0] pattern
);

    localparam logic [PLEN_W-1:0] MAX_LEN = PLEN_W'(PATTERN_MAX);

    logic [PLEN_W-1:0]     len_reg;
    logic [CFG_DATA_W-1:0] pat_lo_reg;
    logic [CFG_DATA_W-1:0] pat_hi_reg;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: len_reg    <= cfg_data[PLEN_W-1:0];
                REG_PATTERN_LOW:    pat_lo_reg <= cfg_data;
                REG_PATTERN_HIGH:   pat_hi_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // A length above the window depth acts as the window depth.
    assign plen    = (len_reg > MAX_LEN) ? FILL_W'(MAX_LEN) : FILL_W'(len_reg);
    assign pattern = {pat_hi_reg, pat_lo_reg};

endmodule

/* hw/rtl/sdaf_window.sv */
// Byte window with append, pattern compare and front drop in one step.
`timescale 1ns / 1ps

module sdaf_window
    import sdaf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    localparam int FILL_W = $clog2(PATTERN_MAX + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  win_cmd_t                    cmd,
    input  logic [FILL_W-1:0]           plen,
    input  logic [PAT_BYTES*BYTE_W-1:0] pattern,
    output win_status_t                 status
);

    localparam int DEPTH = PATTERN_MAX;

    logic [BYTE_W-1:0] win_reg  [DEPTH];
    logic [BYTE_W-1:0] win_next [DEPTH];
    logic [BYTE_W-1:0] cur_win  [DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] cur_fill;
    logic [FILL_W-1:0] shift;
    logic              mism;
    logic              cont;
    logic              hit;
    logic              flush;
    logic              emit;

    // The incoming byte lands at the first free slot.
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            cur_win[k] = (cmd.load && fill_reg == FILL_W'(k)) ? cmd.in_byte : win_reg[k];
        end
        cur_fill = fill_reg + FILL_W'(cmd.load);
    end

    // Compare the oldest plen bytes with the pattern, all positions in parallel.
    always_comb
    begin
        mism = 1'b0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (FILL_W'(k) < plen && cur_win[k] != pattern[k*BYTE_W +: BYTE_W])
            begin
                mism = 1'b1;
            end
        end
    end

    // One pass of the scan: with at least plen bytes held, drop a match, else emit the oldest byte; flush when last.
    always_comb
    begin
        cont      = (cur_fill != '0) && (cur_fill >= plen);
        hit       = cont && (plen != '0) && !mism;
        flush     = !cont && cmd.last && (cur_fill != '0);
        emit      = (cont && !hit) || flush;
        shift     = hit ? plen : FILL_W'(emit);
        fill_next = cur_fill - shift;
    end

    // Move the surviving bytes to the front of the window.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            win_next[i] = cur_win[i];
            for (int s = 1; s < DEPTH - i; s++)
            begin
                if (shift == FILL_W'(s))
                begin
                    win_next[i] = cur_win[i + s];
                end
            end
        end
    end

    assign status.cont      = cont;
    assign status.emit      = emit;
    assign status.empty     = (cur_fill == '0);
    assign status.next_cont = (fill_next != '0) && (fill_next >= plen);
    assign status.emit_byte = cur_win[0];

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.advance)
        begin
            fill_reg <= fill_next;
        end
    end

    // Window bytes; entries at or above the fill count are never read.
    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            win_reg <= win_next;
        end
    end

endmodule

/* hw/rtl/sdaf_port_chk.sv */
// Port-level checker for the substring delete-all filter, bound to the top level.
`timescale 1ns / 1ps
`include "substring_delete_all_filter_core_assert.svh"

module sdaf_port_chk
    import sdaf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              text_ready,
    input logic              result_valid,
    input logic              result_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic              byte_valid,
    input logic              final_result
);

    // A stalled result keeps its payload until the transfer.
    `SDAF_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(out_byte) && $stable(byte_valid) && $stable(final_result), "result changed while stalled")

    // A result without a byte only ever closes a text.
    `SDAF_ASSERT(a_marker_final, result_valid && !byte_valid |-> final_result, "bare marker not flagged final")

    // A bare end marker carries a zero byte.
    `SDAF_ASSERT(a_marker_zero, result_valid && !byte_valid |-> out_byte == '0, "bare marker with nonzero byte")

    // Once reset has been seen at a clock edge, no result is offered and the input side is open.
    `SDAF_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !result_valid && text_ready, "outputs not cleared in reset")

endmodule

bind substring_delete_all_filter_core sdaf_port_chk u_port_chk (.*);
